// File: src/xlsf_pkg.sv
// Shared types, codes and helper functions for the x86 logic and shift flag unit.
`default_nettype none

package xlsf_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [3:0] {
    FN_TEST  = 4'd0,
    FN_AND   = 4'd1,
    FN_XOR   = 4'd2,
    FN_OR    = 4'd3,
    FN_SAR   = 4'd4,
    FN_SHL   = 4'd5,
    FN_SHR   = 4'd6,
    FN_SETCC = 4'd7,
    FN_NOT   = 4'd8,
    FN_ROL   = 4'd9
  } func_e;

  typedef enum logic [1:0] {
    WC_BYTE  = 2'd0,
    WC_WORD  = 2'd1,
    WC_DWORD = 2'd2,
    WC_RSVD  = 2'd3
  } width_e;

  // Condition group selected by the upper three condition bits; the low bit inverts.
  typedef enum logic [2:0] {
    CC_O  = 3'd0,
    CC_B  = 3'd1,
    CC_E  = 3'd2,
    CC_BE = 3'd3,
    CC_S  = 3'd4,
    CC_P  = 3'd5,
    CC_L  = 3'd6,
    CC_LE = 3'd7
  } cond_e;

  typedef struct packed {
    logic cf;
    logic zf;
    logic sf;
    logic of;
    logic pf;
  } flags_t;

  // Word leaving the decode stage.
  typedef struct packed {
    func_e              func;
    width_e             wc;
    logic [DataW-1:0]   dest;
    logic [DataW-1:0]   src;
    logic [CountW-1:0]  cnt;
    logic [CountW-1:0]  rot_n;
    logic               neg;
    logic               setcc;
    logic               wr;
    flags_t             flags;
  } dec_t;

  // Word leaving the execute stage.
  typedef struct packed {
    logic [DataW-1:0]   res;
    width_e             wc;
    logic               wr;
    logic               is_logic;
    logic               is_rol;
    logic               cnt_nz;
    logic               cnt_one;
    flags_t             flags;
  } exe_t;

  function automatic logic [DataW-1:0] width_mask(width_e wc);
    logic [DataW-1:0] m;
    case (wc)
      WC_BYTE: m = DataW'(32'h0000_00FF);
      WC_WORD: m = DataW'(32'h0000_FFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic width_msb(width_e wc, logic [DataW-1:0] v);
    logic b;
    case (wc)
      WC_BYTE: b = v[7];
      WC_WORD: b = v[15];
      default: b = v[DataW-1];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: src/xlsf_decode.sv
// Decode stage: width masking, count reduction, sign capture and setcc evaluation.
`default_nettype none

module xlsf_decode
  import xlsf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [3:0]        func_i,
  input  wire logic [DataW-1:0]  dest_value_i,
  input  wire logic [DataW-1:0]  src_value_i,
  input  wire logic [1:0]        width_code_i,
  input  wire logic [3:0]        cond_code_i,
  input  wire flags_t            flags_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output dec_t                   dec_o
);

  logic   valid_q;
  dec_t   dec_q;
  dec_t   dec_d;
  width_e wc;
  func_e  fn;
  logic   cond_t;
  logic [CountW-1:0] cnt;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign dec_o   = dec_q;

  always_comb begin
    fn  = func_e'(func_i);
    wc  = (width_e'(width_code_i) == WC_RSVD) ? WC_DWORD : width_e'(width_code_i);
    cnt = src_value_i[CountW-1:0];

    case (cond_e'(cond_code_i[3:1]))
      CC_O:    cond_t = flags_i.of;
      CC_B:    cond_t = flags_i.cf;
      CC_E:    cond_t = flags_i.zf;
      CC_BE:   cond_t = flags_i.cf | flags_i.zf;
      CC_S:    cond_t = flags_i.sf;
      CC_P:    cond_t = flags_i.pf;
      CC_L:    cond_t = flags_i.sf ^ flags_i.of;
      default: cond_t = flags_i.zf | (flags_i.sf ^ flags_i.of);
    endcase

    dec_d.func  = fn;
    dec_d.wc    = wc;
    dec_d.dest  = dest_value_i & width_mask(wc);
    dec_d.src   = src_value_i;
    dec_d.cnt   = cnt;
    // Rotate amount is the count modulo the operand width.
    case (wc)
      WC_BYTE: dec_d.rot_n = {2'b00, cnt[2:0]};
      WC_WORD: dec_d.rot_n = {1'b0, cnt[3:0]};
      default: dec_d.rot_n = cnt;
    endcase
    dec_d.neg   = width_msb(wc, dest_value_i);
    dec_d.setcc = cond_t ^ cond_code_i[0];
    case (fn)
      FN_AND, FN_XOR, FN_OR, FN_SAR, FN_SHL,
      FN_SHR, FN_SETCC, FN_NOT, FN_ROL: dec_d.wr = 1'b1;
      default:                          dec_d.wr = 1'b0;
    endcase
    dec_d.flags = flags_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      dec_q <= dec_d;
    end
  end

endmodule

`default_nettype wire

// File: src/xlsf_exec.sv
// Execute stage: logic operations, barrel shifts and the rotate.
`default_nettype none

module xlsf_exec
  import xlsf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire dec_t  dec_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output exe_t       exe_o
);

  logic               valid_q;
  exe_t               exe_q;
  exe_t               exe_d;
  logic [DataW-1:0]   sext;
  logic [DataW-1:0]   rep;
  logic [2*DataW-1:0] dbl;
  logic [DataW-1:0]   r;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign exe_o   = exe_q;

  always_comb begin
    sext = dec_i.neg ? (dec_i.dest | ~width_mask(dec_i.wc)) : dec_i.dest;

    // Replicating the operand to fill the word makes a 32-bit rotate correct
    // in the low bits for every operand width.
    case (dec_i.wc)
      WC_BYTE: rep = {4{dec_i.dest[7:0]}};
      WC_WORD: rep = {2{dec_i.dest[15:0]}};
      default: rep = dec_i.dest;
    endcase
    dbl = {rep, rep} << dec_i.rot_n;

    case (dec_i.func)
      FN_TEST, FN_AND: r = dec_i.dest & dec_i.src;
      FN_XOR:          r = dec_i.dest ^ dec_i.src;
      FN_OR:           r = dec_i.dest | dec_i.src;
      FN_SAR:          r = DataW'($signed(sext) >>> dec_i.cnt);
      FN_SHL:          r = dec_i.dest << dec_i.cnt;
      FN_SHR:          r = dec_i.dest >> dec_i.cnt;
      FN_SETCC:        r = {{(DataW-1){1'b0}}, dec_i.setcc};
      FN_NOT:          r = ~dec_i.dest;
      FN_ROL:          r = dbl[2*DataW-1:DataW];
      default:         r = dec_i.dest;
    endcase

    exe_d.res      = r & width_mask(dec_i.wc);
    exe_d.wc       = dec_i.wc;
    exe_d.wr       = dec_i.wr;
    exe_d.is_logic = (dec_i.func == FN_TEST) || (dec_i.func == FN_AND) ||
                     (dec_i.func == FN_XOR)  || (dec_i.func == FN_OR);
    exe_d.is_rol   = (dec_i.func == FN_ROL);
    exe_d.cnt_nz   = (dec_i.cnt != '0);
    exe_d.cnt_one  = (dec_i.cnt == CountW'(1));
    exe_d.flags    = dec_i.flags;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      exe_q <= exe_d;
    end
  end

endmodule

`default_nettype wire

// File: src/xlsf_flags.sv
// Flag stage: derives the new flags from the result and holds the output word.
`default_nettype none

module xlsf_flags
  import xlsf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire exe_t              exe_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [DataW-1:0]       result_o,
  output logic                   writes_dest_o,
  output flags_t                 flags_o
);

  logic             valid_q;
  logic [DataW-1:0] res_q;
  logic             wr_q;
  flags_t           flags_q;
  flags_t           flags_d;
  logic             msb;

  assign ready_o       = !valid_q || ready_i;
  assign valid_o       = valid_q;
  assign result_o      = res_q;
  assign writes_dest_o = wr_q;
  assign flags_o       = flags_q;

  always_comb begin
    msb     = width_msb(exe_i.wc, exe_i.res);
    flags_d = exe_i.flags;
    if (exe_i.is_logic) begin
      flags_d.cf = 1'b0;
      flags_d.of = 1'b0;
      flags_d.zf = (exe_i.res == '0);
      flags_d.sf = msb;
      flags_d.pf = ~^exe_i.res[7:0];
    end else if (exe_i.is_rol && exe_i.cnt_nz) begin
      flags_d.cf = exe_i.res[0];
      // Overflow is defined only for a single-bit rotate.
      if (exe_i.cnt_one) begin
        flags_d.of = msb ^ exe_i.res[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q   <= exe_i.res;
      wr_q    <= exe_i.wr;
      flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

// File: src/x86_logic_shift_flag_unit.sv
// Top level of the x86 logic, shift and rotate unit with flag generation.
//
//   Channel | Direction | Handshake                    | Payload
//   --------+-----------+------------------------------+--------------------------------------
//   in      | input     | in_valid_i / in_ready_o      | func, dest/src values, width, cond, flags
//   out     | output    | out_valid_o / out_ready_i    | result, writes_dest, new flags
//
// Each word passes three register stages (decode, execute, flags) before its result
// appears; one word can enter every cycle while the output is not stalled.
// The stage depth is set by the 32-bit barrel shifter in the execute stage.
// Reset clears the stage valid bits only; the payload registers are not reset.
// When the output is stalled, each stage holds its word, and empty stages ahead
// of a stall still fill, so nothing is dropped or repeated.
`default_nettype none

module x86_logic_shift_flag_unit
  import xlsf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [3:0]        func_i,
  input  wire logic [DataW-1:0]  dest_value_i,
  input  wire logic [DataW-1:0]  src_value_i,
  input  wire logic [1:0]        width_code_i,
  input  wire logic [3:0]        cond_code_i,
  input  wire logic              cf_in_i,
  input  wire logic              zf_in_i,
  input  wire logic              sf_in_i,
  input  wire logic              of_in_i,
  input  wire logic              pf_in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [DataW-1:0]       result_o,
  output logic                   writes_dest_o,
  output logic                   cf_out_o,
  output logic                   zf_out_o,
  output logic                   sf_out_o,
  output logic                   of_out_o,
  output logic                   pf_out_o
);

  flags_t flags_in;
  flags_t flags_out;
  dec_t   dec;
  exe_t   exe;
  logic   dec_valid;
  logic   dec_ready;
  logic   exe_valid;
  logic   exe_ready;

  assign flags_in.cf = cf_in_i;
  assign flags_in.zf = zf_in_i;
  assign flags_in.sf = sf_in_i;
  assign flags_in.of = of_in_i;
  assign flags_in.pf = pf_in_i;

  xlsf_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .func_i       (func_i),
    .dest_value_i (dest_value_i),
    .src_value_i  (src_value_i),
    .width_code_i (width_code_i),
    .cond_code_i  (cond_code_i),
    .flags_i      (flags_in),
    .valid_o      (dec_valid),
    .ready_i      (dec_ready),
    .dec_o        (dec)
  );

  xlsf_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (exe_valid),
    .ready_i (exe_ready),
    .exe_o   (exe)
  );

  xlsf_flags u_flags (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (exe_valid),
    .ready_o       (exe_ready),
    .exe_i         (exe),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .result_o      (result_o),
    .writes_dest_o (writes_dest_o),
    .flags_o       (flags_out)
  );

  assign cf_out_o = flags_out.cf;
  assign zf_out_o = flags_out.zf;
  assign sf_out_o = flags_out.sf;
  assign of_out_o = flags_out.of;
  assign pf_out_o = flags_out.pf;

endmodule

`default_nettype wire

// File: sim/xlsf_checker.sv
// Checker for the logic/shift flag unit: predicts each word and compares the results.
`timescale 1ns / 100ps

module xlsf_checker
  import xlsf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire logic [3:0]        func_i,
  input  wire logic [DataW-1:0]  dest_value_i,
  input  wire logic [DataW-1:0]  src_value_i,
  input  wire logic [1:0]        width_code_i,
  input  wire logic [3:0]        cond_code_i,
  input  wire logic              cf_in_i,
  input  wire logic              zf_in_i,
  input  wire logic              sf_in_i,
  input  wire logic              of_in_i,
  input  wire logic              pf_in_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire logic [DataW-1:0]  result_i,
  input  wire logic              writes_dest_i,
  input  wire logic              cf_out_i,
  input  wire logic              zf_out_i,
  input  wire logic              sf_out_i,
  input  wire logic              of_out_i,
  input  wire logic              pf_out_i,
  output int                     err_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [3:0]       func;
    logic [DataW-1:0] dest;
    logic [DataW-1:0] src;
    width_e           wc;
    logic [3:0]       cc;
    flags_t           flags;
  } alu_op_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             wr;
    flags_t           flags;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic logic cond_holds(logic [3:0] cc, flags_t f);
    logic t;
    case (cond_e'(cc[3:1]))
      CC_O:    t = f.of;
      CC_B:    t = f.cf;
      CC_E:    t = f.zf;
      CC_BE:   t = f.cf | f.zf;
      CC_S:    t = f.sf;
      CC_P:    t = f.pf;
      CC_L:    t = f.sf ^ f.of;
      default: t = f.zf | (f.sf ^ f.of);
    endcase
    // The low condition bit selects the negated form.
    return t ^ cc[0];
  endfunction

  function automatic alu_result_t compute_alu_result(alu_op_t op);
    alu_result_t res;
    int unsigned bits;
    int unsigned n;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] d;
    logic [DataW-1:0] ext;
    logic [DataW-1:0] r;
    logic [4:0] cnt;
    logic is_logic;
    flags_t fl;
    case (op.wc)
      WC_BYTE: bits = 8;
      WC_WORD: bits = 16;
      default: bits = 32;
    endcase
    mask = (bits == 32) ? '1 : ((32'h1 << bits) - 32'h1);
    d = op.dest & mask;
    cnt = op.src[4:0];
    r = d;
    res.wr = 1'b1;
    is_logic = 1'b0;
    fl = op.flags;
    case (op.func)
      FN_TEST: begin
        r = d & op.src;
        res.wr = 1'b0;
        is_logic = 1'b1;
      end
      FN_AND: begin
        r = d & op.src;
        is_logic = 1'b1;
      end
      FN_XOR: begin
        r = d ^ op.src;
        is_logic = 1'b1;
      end
      FN_OR: begin
        r = d | op.src;
        is_logic = 1'b1;
      end
      FN_SAR: begin
        // Sign-extend to 32 bits first so large counts fill with the sign.
        ext = d;
        if (d[bits-1]) ext = d | ~mask;
        r = $signed(ext) >>> cnt;
      end
      FN_SHL: r = d << cnt;
      FN_SHR: r = d >> cnt;
      FN_SETCC: r = {31'b0, cond_holds(op.cc, op.flags)};
      FN_NOT: r = ~d;
      FN_ROL: begin
        n = cnt % bits;
        if (n != 0) r = (d << n) | (d >> (bits - n));
        r = r & mask;
        // A zero count leaves the flags alone; a nonzero count that wraps n to zero still updates them.
        if (cnt != 5'd0) begin
          fl.cf = r[0];
          if (cnt == 5'd1) fl.of = r[bits-1] ^ fl.cf;
        end
      end
      default: res.wr = 1'b0;
    endcase
    r = r & mask;
    if (is_logic) begin
      fl.cf = 1'b0;
      fl.of = 1'b0;
      fl.zf = (r == '0);
      fl.sf = r[bits-1];
      fl.pf = ~^r[7:0];
    end
    res.result = r;
    res.flags = fl;
    return res;
  endfunction

  task automatic report_field(string name, logic [DataW-1:0] exp_v, logic [DataW-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, got_v);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alu_op_t op;
    alu_result_t exp_r;
    if (!rst_ni) begin
      expected_results.delete();
      err_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        op.func  = func_i;
        op.dest  = dest_value_i;
        op.src   = src_value_i;
        op.wc    = width_e'(width_code_i);
        op.cc    = cond_code_i;
        op.flags = '{cf: cf_in_i, zf: zf_in_i, sf: sf_in_i, of: of_in_i, pf: pf_in_i};
        expected_results.push_back(compute_alu_result(op));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %h with nothing expected", $time, result_i);
          err_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          report_field("result", exp_r.result, result_i);
          report_field("writes_dest", 32'(exp_r.wr), 32'(writes_dest_i));
          report_field("cf", 32'(exp_r.flags.cf), 32'(cf_out_i));
          report_field("zf", 32'(exp_r.flags.zf), 32'(zf_out_i));
          report_field("sf", 32'(exp_r.flags.sf), 32'(sf_out_i));
          report_field("of", 32'(exp_r.flags.of), 32'(of_out_i));
          report_field("pf", 32'(exp_r.flags.pf), 32'(pf_out_i));
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: sim/tb.sv
// Testbench top for the logic/shift flag unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb
  import xlsf_pkg::*;
();

  localparam logic [3:0] FnUnusedLo = 4'd10;
  localparam logic [3:0] FnUnusedHi = 4'd15;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [3:0]       func;
  logic [DataW-1:0] dest_value;
  logic [DataW-1:0] src_value;
  logic [1:0]       width_code;
  logic [3:0]       cond_code;
  flags_t           flags_in;
  logic             out_valid;
  logic             out_ready;
  logic [DataW-1:0] result;
  logic             writes_dest;
  flags_t           flags_out;
  int               err_count;
  int               pending_count;
  int               stall_cycles;
  logic             idle_on;
  logic             hold_req;
  logic             hold_done;

  x86_logic_shift_flag_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .dest_value_i  (dest_value),
    .src_value_i   (src_value),
    .width_code_i  (width_code),
    .cond_code_i   (cond_code),
    .cf_in_i       (flags_in.cf),
    .zf_in_i       (flags_in.zf),
    .sf_in_i       (flags_in.sf),
    .of_in_i       (flags_in.of),
    .pf_in_i       (flags_in.pf),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_o      (result),
    .writes_dest_o (writes_dest),
    .cf_out_o      (flags_out.cf),
    .zf_out_o      (flags_out.zf),
    .sf_out_o      (flags_out.sf),
    .of_out_o      (flags_out.of),
    .pf_out_o      (flags_out.pf)
  );

  xlsf_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .func_i        (func),
    .dest_value_i  (dest_value),
    .src_value_i   (src_value),
    .width_code_i  (width_code),
    .cond_code_i   (cond_code),
    .cf_in_i       (flags_in.cf),
    .zf_in_i       (flags_in.zf),
    .sf_in_i       (flags_in.sf),
    .of_in_i       (flags_in.of),
    .pf_in_i       (flags_in.pf),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .result_i      (result),
    .writes_dest_i (writes_dest),
    .cf_out_i      (flags_out.cf),
    .zf_out_i      (flags_out.zf),
    .sf_out_i      (flags_out.sf),
    .of_out_i      (flags_out.of),
    .pf_out_i      (flags_out.pf),
    .err_count_o   (err_count),
    .pending_o     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random ready bursts, plus one long hold on request.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (idle_on && rst_n && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic [3:0] fn, logic [DataW-1:0] dv, logic [DataW-1:0] sv,
                           logic [1:0] wc, logic [3:0] cc, flags_t fl);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid   = 1'b1;
    func       = fn;
    dest_value = dv;
    src_value  = sv;
    width_code = wc;
    cond_code  = cc;
    flags_in   = fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_word();
    logic [3:0]       fn;
    logic [DataW-1:0] dv;
    logic [DataW-1:0] sv;
    logic [1:0]       wc;
    logic [3:0]       cc;
    flags_t           fl;
    if ($urandom_range(0, 15) == 0) fn = 4'($urandom_range(FnUnusedLo, FnUnusedHi));
    else fn = 4'($urandom_range(FN_TEST, FN_ROL));
    case ($urandom_range(0, 7))
      0: dv = '0;
      1: dv = '1;
      2: dv = 32'h0000_0080;
      3: dv = 32'h0000_8000;
      4: dv = 32'h8000_0000;
      default: dv = $urandom;
    endcase
    sv = $urandom;
    // Bias the count toward the rotate and shift corner values.
    case ($urandom_range(0, 5))
      0: sv[4:0] = 5'($urandom_range(0, 2));
      1: sv[4:0] = $urandom_range(0, 1) ? 5'd8 : 5'd16;
      default: ;
    endcase
    wc = 2'($urandom_range(WC_BYTE, WC_RSVD));
    cc = 4'($urandom_range(0, 15));
    fl = flags_t'(5'($urandom_range(0, 31)));
    send_word(fn, dv, sv, wc, cc, fl);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    func       = '0;
    dest_value = '0;
    src_value  = '0;
    width_code = '0;
    cond_code  = '0;
    flags_in   = '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_word(FN_TEST, 32'h0000_00FF, 32'h0000_0000, WC_BYTE, 4'd0, 5'b11111);
    send_word(FN_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, WC_DWORD, 4'd0, 5'b00000);
    send_word(FN_XOR, 32'h1234_A5A5, 32'hFFFF_0F0F, WC_WORD, 4'd0, 5'b10001);
    send_word(FN_OR, 32'hFFFF_FF80, 32'h0000_0001, WC_BYTE, 4'd0, 5'b00000);
    send_word(FN_SAR, 32'h0000_0080, 32'h0000_0003, WC_BYTE, 4'd0, 5'b10101);
    send_word(FN_SAR, 32'h0000_0080, 32'hFFFF_FFFF, WC_BYTE, 4'd0, 5'b01010);
    send_word(FN_SAR, 32'h8000_0000, 32'h0000_001F, WC_DWORD, 4'd0, 5'b00000);
    send_word(FN_SHL, 32'h0000_FFFF, 32'h0000_0010, WC_WORD, 4'd0, 5'b11111);
    send_word(FN_SHR, 32'hFFFF_FFFF, 32'h0000_0000, WC_DWORD, 4'd0, 5'b00000);
    send_word(FN_SETCC, 32'h0, 32'h0, WC_BYTE, {CC_O, 1'b0}, 5'b00010);
    send_word(FN_SETCC, 32'h0, 32'h0, WC_BYTE, {CC_P, 1'b1}, 5'b00001);
    send_word(FN_SETCC, 32'h0, 32'h0, WC_DWORD, {CC_L, 1'b0}, 5'b00100);
    send_word(FN_SETCC, 32'h0, 32'h0, WC_WORD, {CC_LE, 1'b1}, 5'b01000);
    send_word(FN_NOT, 32'h0000_0000, 32'h0, WC_DWORD, 4'd0, 5'b10101);
    send_word(FN_ROL, 32'h0000_0081, 32'h0000_0000, WC_BYTE, 4'd0, 5'b11111);
    send_word(FN_ROL, 32'h0000_0081, 32'h0000_0001, WC_BYTE, 4'd0, 5'b00000);
    send_word(FN_ROL, 32'h0000_0081, 32'h0000_0008, WC_BYTE, 4'd0, 5'b00000);
    send_word(FN_ROL, 32'h0000_8001, 32'h0000_0010, WC_WORD, 4'd0, 5'b11111);
    send_word(FN_ROL, 32'h8000_0001, 32'hFFFF_FFFF, WC_DWORD, 4'd0, 5'b00000);
    send_word(FN_ROL, 32'h4000_0000, 32'h0000_0001, WC_DWORD, 4'd0, 5'b11111);
    send_word(FN_AND, 32'hF0F0_F0F0, 32'hFFFF_0000, WC_RSVD, 4'd0, 5'b00000);
    send_word(FnUnusedLo, 32'hDEAD_BEEF, 32'h1, WC_WORD, 4'd0, 5'b10110);
    send_word(FnUnusedHi, 32'hDEAD_BEEF, 32'h1, WC_DWORD, 4'd0, 5'b01001);

    repeat (400) send_random_word();

    // Long receiver hold while the sender keeps offering words back to back.
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_random_word();
    idle_on = 1'b1;

    repeat (540) send_random_word();

    idle_on = 1'b0;
    repeat (150) send_random_word();
    in_valid = 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (err_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/xlsf_pkg.sv
src/xlsf_decode.sv
src/xlsf_exec.sv
src/xlsf_flags.sv
src/x86_logic_shift_flag_unit.sv
sim/xlsf_checker.sv
sim/tb.sv
